>>> src/hpst_pkg.sv
// ----------------------------------------------------------------------------
// hpst_pkg
// Shared types, constants and the hall code table of the hall position and
// speed tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package hpst_pkg;

   // Position counter width default and register field widths
   localparam int HPST_COUNT_BITS   = 16;
   localparam int HPST_REG_BITS     = 16;
   localparam int HPST_PERIOD_BITS  = 8;
   localparam int HPST_INDEX_BITS   = 3;
   localparam int HPST_CSR_IDX_BITS = 2;

   // Reset values of the configuration registers
   localparam logic [HPST_REG_BITS-1:0]    HPST_TARGET_RESET = 16'd0;
   localparam logic [HPST_REG_BITS-1:0]    HPST_DUTY_RESET   = 16'd3020;
   localparam logic [HPST_PERIOD_BITS-1:0] HPST_PERIOD_RESET = 8'd5;

   // Register indexes of the configuration port
   typedef enum logic [HPST_CSR_IDX_BITS-1:0] {
      CSR_TARGET_COUNT = 2'd0,
      CSR_DRIVE_DUTY   = 2'd1,
      CSR_STOP_DUTY    = 2'd2,
      CSR_SPEED_PERIOD = 2'd3
   } csr_index_type;

   // Input transaction kind
   typedef enum logic {
      FUNC_HALL = 1'b0,
      FUNC_TICK = 1'b1
   } func_type;

   // Hall sequence index for no valid code, and the indexes at the ends of the electrical cycle
   localparam logic [HPST_INDEX_BITS-1:0] HALL_IDX_NONE  = 3'd0;
   localparam logic [HPST_INDEX_BITS-1:0] HALL_IDX_FIRST = 3'd1;
   localparam logic [HPST_INDEX_BITS-1:0] HALL_IDX_LAST  = 3'd6;

   // Configuration register set
   typedef struct packed {
      logic [HPST_REG_BITS-1:0]    target_count;
      logic [HPST_REG_BITS-1:0]    drive_duty;
      logic [HPST_REG_BITS-1:0]    stop_duty;
      logic [HPST_PERIOD_BITS-1:0] speed_period;
   } cfg_type;

   // One result transaction
   typedef struct packed {
      logic [HPST_REG_BITS-1:0]        position;
      logic [HPST_INDEX_BITS-1:0]      hall_index;
      logic                            hall_error;
      logic [HPST_REG_BITS-1:0]        duty;
      logic signed [HPST_REG_BITS-1:0] speed_delta;
      logic                            speed_valid;
   } rsp_type;

   // Map raw hall levels 3,2,6,4,5,1 to sequence index 1..6, others to none
   function automatic logic [HPST_INDEX_BITS-1:0] hall_decode(input logic [2:0] code);
      logic [HPST_INDEX_BITS-1:0] idx;
      unique case (code)
         3'd1:    idx = 3'd6;
         3'd2:    idx = 3'd2;
         3'd3:    idx = 3'd1;
         3'd4:    idx = 3'd4;
         3'd5:    idx = 3'd5;
         3'd6:    idx = 3'd3;
         default: idx = HALL_IDX_NONE;
      endcase
      return idx;
   endfunction

endpackage

`default_nettype wire

>>> src/hpst_ifs.sv
// ----------------------------------------------------------------------------
// hpst channel interfaces
// Valid/ready channels of the tracker: hall/tick requests, results and
// register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface hpst_req_if import hpst_pkg::*; ();
   logic       valid;
   logic       ready;
   logic       func;
   logic [2:0] hall_bits;

   modport source (output valid, func, hall_bits, input ready);
   modport sink   (input valid, func, hall_bits, output ready);
endinterface

interface hpst_rsp_if import hpst_pkg::*; ();
   logic                            valid;
   logic                            ready;
   logic [HPST_REG_BITS-1:0]        position;
   logic [HPST_INDEX_BITS-1:0]      hall_index;
   logic                            hall_error;
   logic [HPST_REG_BITS-1:0]        duty;
   logic signed [HPST_REG_BITS-1:0] speed_delta;
   logic                            speed_valid;

   modport source (output valid, position, hall_index, hall_error, duty, speed_delta,
                   speed_valid, input ready);
   modport sink   (input valid, position, hall_index, hall_error, duty, speed_delta,
                   speed_valid, output ready);
endinterface

interface hpst_csr_if import hpst_pkg::*; ();
   logic                         valid;
   logic                         ready;
   logic [HPST_CSR_IDX_BITS-1:0] index;
   logic [HPST_REG_BITS-1:0]     data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> src/hpst_core.sv
// ----------------------------------------------------------------------------
// hpst_core
// Tracker state: hall decode, position counter, speed window, and the
// result of each accepted transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module hpst_core import hpst_pkg::*; #(
   parameter int COUNT_BITS = HPST_COUNT_BITS
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       accept,
   input  wire logic       func,
   input  wire logic [2:0] hall_bits,
   input  wire cfg_type    cfg,
   output rsp_type         result
);

   localparam int CMP_BITS = (COUNT_BITS > HPST_REG_BITS) ? COUNT_BITS : HPST_REG_BITS;

   logic [HPST_INDEX_BITS-1:0]  last_index_ff, last_index_in;
   logic [1:0]                  event_count_ff, event_count_in;
   logic [COUNT_BITS-1:0]       position_ff, position_in;
   logic [HPST_PERIOD_BITS-1:0] tick_count_ff, tick_count_in;
   logic [COUNT_BITS-1:0]       window_start_ff, window_start_in;
   logic [COUNT_BITS-1:0]       last_speed_ff, last_speed_in;

   logic [HPST_INDEX_BITS-1:0]  idx;
   logic [1:0]                  event_step;
   logic                        wrap;
   logic                        step_up;
   logic                        step_down;
   logic                        is_hall;
   logic [HPST_PERIOD_BITS-1:0] tick_step;
   logic                        window_close;
   logic [CMP_BITS-1:0]         pos_wide;
   logic [CMP_BITS-1:0]         speed_wide;
   logic [CMP_BITS-1:0]         target_wide;

   // Decode the hall code and work out the direction of the step
   always_comb begin
      is_hall    = (func_type'(func) == FUNC_HALL);
      idx        = hall_decode(hall_bits);
      event_step = (event_count_ff == 2'd3) ? 2'd3 : event_count_ff + 2'd1;
      wrap       = ((idx == HALL_IDX_FIRST) && (last_index_ff == HALL_IDX_LAST)) ||
                   ((idx == HALL_IDX_LAST) && (last_index_ff == HALL_IDX_FIRST));
      if (wrap) begin
         step_up   = idx > last_index_ff;
         step_down = idx < last_index_ff;
      end else begin
         step_up   = idx < last_index_ff;
         step_down = idx > last_index_ff;
      end
      tick_step    = tick_count_ff + HPST_PERIOD_BITS'(1);
      window_close = !is_hall && (tick_step >= cfg.speed_period);
   end

   // Next state: a hall transaction moves the count, a tick advances the window
   always_comb begin
      last_index_in   = last_index_ff;
      event_count_in  = event_count_ff;
      position_in     = position_ff;
      tick_count_in   = tick_count_ff;
      window_start_in = window_start_ff;
      last_speed_in   = last_speed_ff;
      if (accept) begin
         if (is_hall) begin
            last_index_in  = idx;
            event_count_in = event_step;
            if (step_up) begin
               position_in = position_ff + COUNT_BITS'(1);
            end else if (step_down && (event_step == 2'd3)) begin
               position_in = position_ff - COUNT_BITS'(1);
            end
         end else if (window_close) begin
            last_speed_in   = position_ff - window_start_ff;
            window_start_in = position_ff;
            tick_count_in   = '0;
         end else begin
            tick_count_in = tick_step;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_index_ff   <= HALL_IDX_NONE;
         event_count_ff  <= '0;
         position_ff     <= '0;
         tick_count_ff   <= '0;
         window_start_ff <= '0;
         last_speed_ff   <= '0;
      end else begin
         last_index_ff   <= last_index_in;
         event_count_ff  <= event_count_in;
         position_ff     <= position_in;
         tick_count_ff   <= tick_count_in;
         window_start_ff <= window_start_in;
         last_speed_ff   <= last_speed_in;
      end
   end

   // Build the result from the updated state
   always_comb begin
      pos_wide           = CMP_BITS'(position_in);
      speed_wide         = CMP_BITS'(last_speed_in);
      target_wide        = CMP_BITS'(cfg.target_count);
      result.position    = pos_wide[HPST_REG_BITS-1:0];
      result.hall_index  = is_hall ? idx : last_index_ff;
      result.hall_error  = is_hall && (idx == HALL_IDX_NONE);
      result.duty        = (pos_wide <= target_wide) ? cfg.drive_duty : cfg.stop_duty;
      result.speed_delta = speed_wide[HPST_REG_BITS-1:0];
      result.speed_valid = window_close;
   end

endmodule

`default_nettype wire

>>> src/hpst_rsp_buf.sv
// ----------------------------------------------------------------------------
// hpst_rsp_buf
// Result register with a skid stage, so a stalled sink does not stop the
// next transaction from being taken.
// ----------------------------------------------------------------------------
`default_nettype none

module hpst_rsp_buf import hpst_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    in_valid,
   input  wire rsp_type in_data,
   output logic         in_ready,
   output logic         out_valid,
   output rsp_type      out_data,
   input  wire logic    out_ready
);

   logic    main_valid_ff, main_valid_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type main_ff, main_in;
   rsp_type skid_ff, skid_in;

   assign in_ready  = !skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_data  = main_ff;

   // Refill the output register from skid first, park in skid when stalled
   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (!main_valid_ff || out_ready) begin
         if (skid_valid_ff) begin
            main_valid_in = 1'b1;
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            main_valid_in = in_valid;
            main_in       = in_data;
         end
      end else if (in_valid && !skid_valid_ff) begin
         skid_valid_in = 1'b1;
         skid_in       = in_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // Payload needs no reset
   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

endmodule

`default_nettype wire

>>> src/hall_position_speed_tracker.sv
// ----------------------------------------------------------------------------
// hall_position_speed_tracker
// Each request transaction is a hall change (three hall levels) or a timer
// tick, and gives exactly one result transaction. A request is taken in every
// cycle: the position counter and speed window update as it is taken, and a
// result register plus one skid entry hold results while the sink stalls; the
// request side stalls only when both are full. Hall codes 3,2,6,4,5,1 give
// index 1..6; the position counts up as the index steps down and, from the
// third hall change on, down as it steps up. Every speed_period ticks the
// position change over the window is reported in speed_delta with speed_valid
// set. duty is drive_duty while position is at or below target_count, else
// stop_duty. The user must write registers through the csr channel while the
// block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module hall_position_speed_tracker import hpst_pkg::*; #(
   parameter int COUNT_BITS = HPST_COUNT_BITS
) (
   input wire logic  clock,
   input wire logic  reset,
   hpst_req_if.sink  req_ch,
   hpst_rsp_if.source rsp_ch,
   hpst_csr_if.sink  csr_ch
);

   cfg_type cfg_ff, cfg_in;
   rsp_type core_result;
   rsp_type out_data;
   logic    req_accept;
   logic    buf_ready;

   // Register writes are always taken
   assign csr_ch.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_ch.valid) begin
         unique case (csr_index_type'(csr_ch.index))
            CSR_TARGET_COUNT: cfg_in.target_count = csr_ch.data;
            CSR_DRIVE_DUTY:   cfg_in.drive_duty   = csr_ch.data;
            CSR_STOP_DUTY:    cfg_in.stop_duty    = csr_ch.data;
            CSR_SPEED_PERIOD: cfg_in.speed_period = csr_ch.data[HPST_PERIOD_BITS-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.target_count <= HPST_TARGET_RESET;
         cfg_ff.drive_duty   <= HPST_DUTY_RESET;
         cfg_ff.stop_duty    <= HPST_DUTY_RESET;
         cfg_ff.speed_period <= HPST_PERIOD_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Take a request whenever the result buffer has room
   assign req_ch.ready = buf_ready;
   assign req_accept   = req_ch.valid && buf_ready;

   hpst_core #(
      .COUNT_BITS (COUNT_BITS)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .accept    (req_accept),
      .func      (req_ch.func),
      .hall_bits (req_ch.hall_bits),
      .cfg       (cfg_ff),
      .result    (core_result)
   );

   hpst_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_accept),
      .in_data   (core_result),
      .in_ready  (buf_ready),
      .out_valid (rsp_ch.valid),
      .out_data  (out_data),
      .out_ready (rsp_ch.ready)
   );

   assign rsp_ch.position    = out_data.position;
   assign rsp_ch.hall_index  = out_data.hall_index;
   assign rsp_ch.hall_error  = out_data.hall_error;
   assign rsp_ch.duty        = out_data.duty;
   assign rsp_ch.speed_delta = out_data.speed_delta;
   assign rsp_ch.speed_valid = out_data.speed_valid;

endmodule

`default_nettype wire

>>> src/hpst_checker.sv
// ----------------------------------------------------------------------------
// hpst_checker
// Port-level checks of the tracker, attached to the top level by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module hpst_checker import hpst_pkg::*; (
   input wire logic                       clock,
   input wire logic                       reset,
   input wire logic                       req_valid,
   input wire logic                       req_ready,
   input wire logic                       rsp_valid,
   input wire logic                       rsp_ready,
   input wire logic [HPST_REG_BITS-1:0]   rsp_position,
   input wire logic [HPST_INDEX_BITS-1:0] rsp_hall_index,
   input wire logic                       rsp_hall_error,
   input wire logic                       rsp_speed_valid
);

   // Hold a stalled result transaction valid, with its position unchanged
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_position))
      else $error("result transaction dropped or changed while stalled");

   // No result may appear straight after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // A rising result valid needs a request accepted in the cycle before
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready))
      else $error("result appeared without a request");

   // An invalid hall code reports index zero and closes no window
   a_err_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_hall_error |-> (rsp_hall_index == HALL_IDX_NONE) && !rsp_speed_valid)
      else $error("hall error with non-zero index or speed window");

endmodule

bind hall_position_speed_tracker hpst_checker u_hpst_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_ch.valid),
   .req_ready       (req_ch.ready),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_position    (rsp_ch.position),
   .rsp_hall_index  (rsp_ch.hall_index),
   .rsp_hall_error  (rsp_ch.hall_error),
   .rsp_speed_valid (rsp_ch.speed_valid)
);

`default_nettype wire
